// File: rtl/gpfp_pkg.sv
`default_nettype none

package gpfp_pkg;

    localparam int CHAR_W   = 8;
    localparam int FIELD_W  = 5;
    localparam int POS_W    = 3;
    localparam int ACC_W    = 30;
    localparam int FC_W     = 3;
    localparam int POW_W    = 20;
    localparam int PROD_W   = ACC_W + POW_W;
    localparam int OUT_DATA_W = 80;

    localparam int DEF_MAX_FIELDS  = 20;
    localparam int DEF_FRAC_DIGITS = 4;
    localparam int MIN_FIELDS      = 14;
    localparam int HDR_LEN         = 6;

    localparam logic [ACC_W-1:0]  VAL_CAP = 30'd999999999;
    localparam logic [POS_W-1:0]  POS_MAX = 3'd7;

    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // field numbers with a meaning
    localparam logic [FIELD_W-1:0] FIELD_HDR     = 5'd0;
    localparam logic [FIELD_W-1:0] FIELD_LAT     = 5'd2;
    localparam logic [FIELD_W-1:0] FIELD_LAT_DIR = 5'd3;
    localparam logic [FIELD_W-1:0] FIELD_LON     = 5'd4;
    localparam logic [FIELD_W-1:0] FIELD_LON_DIR = 5'd5;

    // conversion state of one numeric field
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [FC_W-1:0]  frac_cnt;
        logic             point_seen;
        logic             stopped;
    } num_state_t;

    // expected header text, one character per position
    function automatic logic [CHAR_W-1:0] hdr_char(input logic [POS_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            3'd0:    c = 8'h24; // $
            3'd1:    c = 8'h47; // G
            3'd2:    c = 8'h50; // P
            3'd3:    c = 8'h47; // G
            3'd4:    c = 8'h47; // G
            3'd5:    c = 8'h41; // A
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // 10^k for the missing fraction digits
    function automatic logic [POW_W-1:0] pow10(input logic [FC_W-1:0] k);
        logic [POW_W-1:0] p;
        case (k)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

    // largest accumulator value that does not saturate after scaling by 10^k
    function automatic logic [ACC_W-1:0] cap_quot(input logic [FC_W-1:0] k);
        logic [ACC_W-1:0] q;
        case (k)
            3'd0:    q = VAL_CAP;
            3'd1:    q = ACC_W'(VAL_CAP / 10);
            3'd2:    q = ACC_W'(VAL_CAP / 100);
            3'd3:    q = ACC_W'(VAL_CAP / 1000);
            3'd4:    q = ACC_W'(VAL_CAP / 10000);
            3'd5:    q = ACC_W'(VAL_CAP / 100000);
            3'd6:    q = ACC_W'(VAL_CAP / 1000000);
            default: q = VAL_CAP;
        endcase
        return q;
    endfunction

endpackage

`default_nettype wire

// File: rtl/gpfp_num_acc.sv
`default_nettype none

module gpfp_num_acc #(
    parameter int FRAC_DIGITS = gpfp_pkg::DEF_FRAC_DIGITS
) (
    input  wire logic                        en,
    input  wire logic [gpfp_pkg::CHAR_W-1:0] char_in,
    input  wire gpfp_pkg::num_state_t        cur,
    output gpfp_pkg::num_state_t             nxt
);
    import gpfp_pkg::*;

    logic              is_digit;
    logic [ACC_W+3:0]  acc_ext;
    logic [ACC_W+3:0]  acc_mul;
    logic              acc_sat;
    logic              frac_full;

    // acc * 10 + digit, checked against the cap
    assign is_digit  = char_in inside {[CHAR_ZERO:CHAR_NINE]};
    assign acc_ext   = (ACC_W+4)'(cur.acc);
    assign acc_mul   = (acc_ext << 3) + (acc_ext << 1) + (ACC_W+4)'(char_in[3:0]);
    assign acc_sat   = acc_mul > (ACC_W+4)'(VAL_CAP);
    assign frac_full = cur.frac_cnt >= FC_W'(FRAC_DIGITS);

    // one character step of the conversion
    always_comb begin
        nxt = cur;
        if (en && !cur.stopped) begin
            if (is_digit) begin
                if (!(cur.point_seen && frac_full)) begin
                    if (cur.point_seen) begin
                        nxt.frac_cnt = cur.frac_cnt + 1'b1;
                    end
                    nxt.acc = acc_sat ? VAL_CAP : acc_mul[ACC_W-1:0];
                end
            end else if (char_in == CHAR_POINT && !cur.point_seen) begin
                nxt.point_seen = 1'b1;
            end else begin
                nxt.stopped = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/gpfp_num_scale.sv
`default_nettype none

module gpfp_num_scale #(
    parameter int FRAC_DIGITS = gpfp_pkg::DEF_FRAC_DIGITS
) (
    input  wire logic                       ok,
    input  wire gpfp_pkg::num_state_t       st,
    output logic [gpfp_pkg::ACC_W-1:0]      value
);
    import gpfp_pkg::*;

    logic [FC_W-1:0]   shift;
    logic [PROD_W-1:0] prod;
    logic              sat;

    // fill the missing fraction digits with a power of ten
    assign shift = FC_W'(FRAC_DIGITS) - st.frac_cnt;
    assign prod  = PROD_W'(st.acc) * PROD_W'(pow10(shift));
    assign sat   = st.acc > cap_quot(shift);

    // zero for a rejected sentence, cap on overflow
    always_comb begin
        if (!ok) begin
            value = '0;
        end else if (sat) begin
            value = VAL_CAP;
        end else begin
            value = prod[ACC_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: rtl/gga_position_field_parser_unit.sv
// A result is registered after the transfer of the sentence's last character
// (field update into a snapshot register, then scaling into the output register).
// Throughput: one character per cycle; the parser stalls only while both the snapshot
// and the output register hold results that the sink has not taken.
// Reset: aresetn low clears the field counters, conversion state and both valid flags.
`default_nettype none

module gga_position_field_parser_unit #(
    parameter int MAX_FIELDS  = gpfp_pkg::DEF_MAX_FIELDS,
    parameter int FRAC_DIGITS = gpfp_pkg::DEF_FRAC_DIGITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,  // char_byte
    input  wire logic                            s_tlast,  // sentence_end
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // latitude_value[29:0], latitude_dir[37:30], longitude_value[67:38],
    // longitude_dir[75:68], zero padding[79:76]
    output logic [gpfp_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [0:0]                           m_tuser   // valid_res
);
    import gpfp_pkg::*;

    // parser state
    logic [FIELD_W-1:0] field_reg, field_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               hdr_reg, hdr_next;
    num_state_t         lat_reg, lat_next;
    num_state_t         lon_reg, lon_next;
    logic [CHAR_W-1:0]  lat_dir_reg, lat_dir_next;
    logic [CHAR_W-1:0]  lon_dir_reg, lon_dir_next;

    // snapshot of a finished sentence
    logic               snap_valid_reg;
    logic               snap_ok_reg;
    num_state_t         snap_lat_reg;
    num_state_t         snap_lon_reg;
    logic [CHAR_W-1:0]  snap_lat_dir_reg;
    logic [CHAR_W-1:0]  snap_lon_dir_reg;

    // output register
    logic               m_valid_reg;
    logic               out_ok_reg;
    logic [ACC_W-1:0]   out_lat_val_reg;
    logic [ACC_W-1:0]   out_lon_val_reg;
    logic [CHAR_W-1:0]  out_lat_dir_reg;
    logic [CHAR_W-1:0]  out_lon_dir_reg;

    logic               out_ready;
    logic               snap_ready;
    logic               in_xfer;
    logic [CHAR_W-1:0]  char_in;
    logic               is_comma;
    logic               hdr_pos;
    logic               final_hdr;
    logic               final_ok;
    logic [ACC_W-1:0]   lat_val;
    logic [ACC_W-1:0]   lon_val;

    // handshake chain through the two register stages
    assign out_ready  = !m_valid_reg || m_tready;
    assign snap_ready = !snap_valid_reg || out_ready;
    assign s_tready   = snap_ready;
    assign in_xfer    = s_tvalid && s_tready;

    assign char_in  = s_tdata;
    assign is_comma = char_in == CHAR_COMMA;
    assign hdr_pos  = field_reg == FIELD_HDR && pos_reg < POS_W'(HDR_LEN);

    // numeric field conversion
    gpfp_num_acc #(.FRAC_DIGITS(FRAC_DIGITS)) u_lat_acc (
        .en      (!is_comma && field_reg == FIELD_LAT),
        .char_in (char_in),
        .cur     (lat_reg),
        .nxt     (lat_next)
    );

    gpfp_num_acc #(.FRAC_DIGITS(FRAC_DIGITS)) u_lon_acc (
        .en      (!is_comma && field_reg == FIELD_LON),
        .char_in (char_in),
        .cur     (lon_reg),
        .nxt     (lon_next)
    );

    // field counting, header check and direction characters
    always_comb begin
        field_next   = field_reg;
        pos_next     = pos_reg;
        hdr_next     = hdr_reg;
        lat_dir_next = lat_dir_reg;
        lon_dir_next = lon_dir_reg;
        if (is_comma) begin
            if (hdr_pos) begin
                hdr_next = 1'b0;
            end
            if (field_reg < FIELD_W'(MAX_FIELDS - 1)) begin
                field_next = field_reg + 1'b1;
            end
            pos_next = '0;
        end else begin
            if (hdr_pos && char_in != hdr_char(pos_reg)) begin
                hdr_next = 1'b0;
            end
            if (field_reg == FIELD_LAT_DIR && pos_reg == '0) begin
                lat_dir_next = char_in;
            end
            if (field_reg == FIELD_LON_DIR && pos_reg == '0) begin
                lon_dir_next = char_in;
            end
            if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // sentence verdict after its last character
    assign final_hdr = hdr_next && !(field_next == FIELD_HDR && pos_next < POS_W'(HDR_LEN));
    assign final_ok  = final_hdr && field_next >= FIELD_W'(MIN_FIELDS - 1);

    // parser state update, back to reset values after the last character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg   <= '0;
            pos_reg     <= '0;
            hdr_reg     <= 1'b1;
            lat_reg     <= '0;
            lon_reg     <= '0;
            lat_dir_reg <= '0;
            lon_dir_reg <= '0;
        end else if (in_xfer) begin
            if (s_tlast) begin
                field_reg   <= '0;
                pos_reg     <= '0;
                hdr_reg     <= 1'b1;
                lat_reg     <= '0;
                lon_reg     <= '0;
                lat_dir_reg <= '0;
                lon_dir_reg <= '0;
            end else begin
                field_reg   <= field_next;
                pos_reg     <= pos_next;
                hdr_reg     <= hdr_next;
                lat_reg     <= lat_next;
                lon_reg     <= lon_next;
                lat_dir_reg <= lat_dir_next;
                lon_dir_reg <= lon_dir_next;
            end
        end
    end

    // snapshot stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (snap_ready) begin
            snap_valid_reg <= in_xfer && s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready && in_xfer && s_tlast) begin
            snap_ok_reg      <= final_ok;
            snap_lat_reg     <= lat_next;
            snap_lon_reg     <= lon_next;
            snap_lat_dir_reg <= final_ok ? lat_dir_next : '0;
            snap_lon_dir_reg <= final_ok ? lon_dir_next : '0;
        end
    end

    // scaling to fixed point
    gpfp_num_scale #(.FRAC_DIGITS(FRAC_DIGITS)) u_lat_scale (
        .ok    (snap_ok_reg),
        .st    (snap_lat_reg),
        .value (lat_val)
    );

    gpfp_num_scale #(.FRAC_DIGITS(FRAC_DIGITS)) u_lon_scale (
        .ok    (snap_ok_reg),
        .st    (snap_lon_reg),
        .value (lon_val)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && snap_valid_reg) begin
            out_ok_reg      <= snap_ok_reg;
            out_lat_val_reg <= lat_val;
            out_lon_val_reg <= lon_val;
            out_lat_dir_reg <= snap_lat_dir_reg;
            out_lon_dir_reg <= snap_lon_dir_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {4'b0, out_lon_dir_reg, out_lon_val_reg, out_lat_dir_reg, out_lat_val_reg};

endmodule

`default_nettype wire

// File: rtl/gpfp_checker.sv
`default_nettype none

module gpfp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic [0:0]  m_tuser
);

    // a rejected sentence carries an all-zero payload
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 80'd0)
        else $error("rejected sentence with nonzero payload");

    // converted values never pass the cap
    a_value_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[29:0] <= 30'd999999999 && m_tdata[67:38] <= 30'd999999999)
        else $error("position value above cap");

    // input backpressure only while a result waits at the output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a pending result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind gga_position_field_parser_unit gpfp_checker u_gpfp_checker (.*);

`default_nettype wire
